// File: design/alhr_pkg.sv
// Shared constants and types for the attitude level-hold regulator.
// No dependencies; used by attitude_level_hold_regulator.
package alhr_pkg;

  // default angle width, signed Q2.13 at 16 bits
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // serial multiplier: one multiplier bit per cycle, 16-bit gain and alpha
  localparam int unsigned MULT_BITS = 16;
  localparam int unsigned CNT_W     = $clog2(MULT_BITS);

  // configuration channel
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORRECTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMMAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONTACTS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MARGIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 3'd5;

  // register reset values
  localparam logic [15:0]        GAIN_RST           = 16'd19661;
  localparam logic [14:0]        MAX_CORRECTION_RST = 15'd1475;
  localparam logic [14:0]        MAX_COMMAND_RST    = 15'd2458;
  localparam logic [2:0]         MIN_CONTACTS_RST   = 3'd3;
  localparam logic signed [15:0] MIN_MARGIN_RST     = 16'sd100;
  localparam logic [15:0]        FILTER_ALPHA_RST   = 16'd8192;

  // tuser bit positions on the input side
  localparam int unsigned U_ROLL_SP_OK   = 0;
  localparam int unsigned U_PITCH_SP_OK  = 1;
  localparam int unsigned U_ROLL_MS_OK   = 2;
  localparam int unsigned U_PITCH_MS_OK  = 3;
  localparam int unsigned U_POSE_MEAS    = 4;
  localparam int unsigned U_POSE_INFER   = 5;
  localparam int unsigned IN_USER_W      = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_FUPD,
    ST_HLOAD,
    ST_HOLD,
    ST_CORR,
    ST_CMD
  } alhr_state_e;

endpackage

// File: design/attitude_level_hold_regulator.sv
// Attitude level-hold regulator: low-pass attitude estimate plus clamped
// proportional correction, built around a pair of bit-serial multipliers.
// Depends on alhr_pkg.
//
//   channel   direction  handshake              payload
//   s_axis    in         tvalid/tready          tdata: setpoints, measurements,
//                                               contacts, margin; tuser: flags
//   m_axis    out        tvalid/tready          tdata: commands; tuser: hold
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The result is loaded into the output register after two 16-step shift-add
// multiplies, one multiplier bit per cycle, both axes in parallel lanes: the
// filter blend, then the filter update and gain load, then the gain multiply,
// then clamp and command. A new word is taken only while the sequencer is
// idle; the output register lets the next word start while the previous
// result waits. If the previous result is still not taken at the end, the
// sequencer holds in its last step.
// Reset (async, active low) restores the register defaults, clears the
// filter state and marks the filter unseeded. cfg_ready is always high.
module attitude_level_hold_regulator #(
  parameter int unsigned ANGLE_BITS = alhr_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // in word
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata, low bit up: roll request, pitch request, roll measured,
  // pitch measured, contact count, stability margin, zero pad
  input  logic [((4*ANGLE_BITS+19+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser, low bit up: roll request ok, pitch request ok, roll measured ok,
  // pitch measured ok, pose measured, pose inferred
  input  logic [alhr_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  // out word
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata, low bit up: roll command, pitch command, zero pad
  output logic [((2*ANGLE_BITS+7)/8)*8-1:0]   m_axis_tdata_o,
  // tuser: hold_active
  output logic                                m_axis_tuser_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [alhr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [alhr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned A     = ANGLE_BITS;
  localparam int unsigned OUT_W = ((2*A+7)/8)*8;
  // width for correction and command math; must hold the 15-bit limits too
  localparam int unsigned CW    = (A+4 > 17) ? A+4 : 17;
  localparam logic [alhr_pkg::CNT_W-1:0] CNT_LAST =
    alhr_pkg::CNT_W'(alhr_pkg::MULT_BITS-1);

  // ---------------------------------------------------------------- config
  logic [15:0]        gain_q;
  logic [14:0]        max_corr_q;
  logic [14:0]        max_cmd_q;
  logic [2:0]         min_cont_q;
  logic signed [15:0] min_margin_q;
  logic [15:0]        alpha_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= alhr_pkg::GAIN_RST;
      max_corr_q   <= alhr_pkg::MAX_CORRECTION_RST;
      max_cmd_q    <= alhr_pkg::MAX_COMMAND_RST;
      min_cont_q   <= alhr_pkg::MIN_CONTACTS_RST;
      min_margin_q <= alhr_pkg::MIN_MARGIN_RST;
      alpha_q      <= alhr_pkg::FILTER_ALPHA_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        alhr_pkg::CFG_GAIN:           gain_q       <= cfg_data_i;
        alhr_pkg::CFG_MAX_CORRECTION: max_corr_q   <= cfg_data_i[14:0];
        alhr_pkg::CFG_MAX_COMMAND:    max_cmd_q    <= cfg_data_i[14:0];
        alhr_pkg::CFG_MIN_CONTACTS:   min_cont_q   <= cfg_data_i[2:0];
        alhr_pkg::CFG_MIN_MARGIN:     min_margin_q <= $signed(cfg_data_i);
        alhr_pkg::CFG_FILTER_ALPHA:   alpha_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  alhr_pkg::alhr_state_e state_q, state_d;
  logic [alhr_pkg::CNT_W-1:0] cnt_q;
  logic                       out_vld_q;
  logic                       accept;
  logic                       out_load;

  assign s_axis_tready_o = (state_q == alhr_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      alhr_pkg::ST_IDLE:  if (s_axis_tvalid_i) state_d = alhr_pkg::ST_FILT;
      alhr_pkg::ST_FILT:  if (cnt_q == CNT_LAST) state_d = alhr_pkg::ST_FUPD;
      alhr_pkg::ST_FUPD:  state_d = alhr_pkg::ST_HLOAD;
      alhr_pkg::ST_HLOAD: state_d = alhr_pkg::ST_HOLD;
      alhr_pkg::ST_HOLD:  if (cnt_q == CNT_LAST) state_d = alhr_pkg::ST_CORR;
      alhr_pkg::ST_CORR:  state_d = alhr_pkg::ST_CMD;
      alhr_pkg::ST_CMD: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = alhr_pkg::ST_IDLE;
        end
      end
      default: state_d = alhr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alhr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- input decode
  logic signed [A-1:0] in_sp[2];
  logic signed [A-1:0] in_ms[2];
  logic [2:0]          in_cont;
  logic signed [15:0]  in_margin;
  logic                in_enable;

  always_comb begin
    in_sp[0]  = s_axis_tuser_i[alhr_pkg::U_ROLL_SP_OK]  ? s_axis_tdata_i[A-1:0]     : '0;
    in_sp[1]  = s_axis_tuser_i[alhr_pkg::U_PITCH_SP_OK] ? s_axis_tdata_i[2*A-1:A]   : '0;
    in_ms[0]  = s_axis_tuser_i[alhr_pkg::U_ROLL_MS_OK]  ? s_axis_tdata_i[3*A-1:2*A] : '0;
    in_ms[1]  = s_axis_tuser_i[alhr_pkg::U_PITCH_MS_OK] ? s_axis_tdata_i[4*A-1:3*A] : '0;
    in_cont   = s_axis_tdata_i[4*A+2:4*A];
    in_margin = $signed(s_axis_tdata_i[4*A+18:4*A+3]);
    // measured pose holds on its own; inferred pose needs adequate support
    in_enable = s_axis_tuser_i[alhr_pkg::U_POSE_MEAS] ||
                (s_axis_tuser_i[alhr_pkg::U_POSE_INFER] &&
                 (in_cont >= min_cont_q) && (in_margin >= min_margin_q));
  end

  // ---------------------------------------------------------------- lanes
  // lane 0 is roll, lane 1 is pitch
  logic signed [A-1:0]   sp_q[2];
  logic signed [A-1:0]   ms_q[2];
  logic signed [A-1:0]   filt_q[2];
  logic                  seeded_q;
  logic                  en_q;
  logic signed [A:0]     d_q[2];      // multiplicand: difference
  logic signed [A+1:0]   acc_q[2];    // high part of running product
  logic                  lsb_q[2];    // last bit shifted out
  logic [alhr_pkg::MULT_BITS-1:0] mbits_q;
  logic signed [CW-1:0]  corr_q[2];
  logic signed [A-1:0]   cmd_q[2];
  logic                  hold_q;

  logic signed [A+2:0]   step_sum[2];
  logic signed [A+2:0]   quot[2];     // floor(product / 2^15)
  logic signed [A+3:0]   fsum[2];
  logic signed [A-1:0]   fsat[2];
  logic signed [A:0]     in_diff[2];
  logic signed [A:0]     hold_diff[2];
  logic signed [CW-1:0]  q_ext[2];
  logic signed [CW-1:0]  lim_corr;
  logic signed [CW-1:0]  corr_clamp[2];
  logic signed [CW:0]    csum[2];
  logic signed [CW:0]    lim_cmd;
  logic signed [CW:0]    cclamp[2];
  logic signed [A-1:0]   csat[2];

  always_comb begin
    lim_corr = $signed({{(CW-15){1'b0}}, max_corr_q});
    lim_cmd  = $signed({{(CW+1-15){1'b0}}, max_cmd_q});
    for (int l = 0; l < 2; l++) begin
      // one shift-add step of the serial multiplier
      step_sum[l] = {acc_q[l][A+1], acc_q[l]} +
                    (mbits_q[0] ? {{2{d_q[l][A]}}, d_q[l]} : '0);
      quot[l]     = {acc_q[l], lsb_q[l]};

      // filter update with saturation to the angle range
      fsum[l] = {{4{filt_q[l][A-1]}}, filt_q[l]} + {quot[l][A+2], quot[l]};
      if (fsum[l][A+3:A-1] == '0 || fsum[l][A+3:A-1] == '1) begin
        fsat[l] = fsum[l][A-1:0];
      end else begin
        fsat[l] = {fsum[l][A+3], {(A-1){~fsum[l][A+3]}}};
      end

      in_diff[l]   = {in_ms[l][A-1], in_ms[l]} - {filt_q[l][A-1], filt_q[l]};
      hold_diff[l] = {sp_q[l][A-1], sp_q[l]} - {filt_q[l][A-1], filt_q[l]};

      // correction clamp
      q_ext[l] = CW'(quot[l]);
      if (q_ext[l] > lim_corr) begin
        corr_clamp[l] = lim_corr;
      end else if (q_ext[l] < -lim_corr) begin
        corr_clamp[l] = -lim_corr;
      end else begin
        corr_clamp[l] = q_ext[l];
      end

      // command clamp, then saturate to the angle range
      csum[l] = (CW+1)'(sp_q[l]) + {corr_q[l][CW-1], corr_q[l]};
      if (csum[l] > lim_cmd) begin
        cclamp[l] = lim_cmd;
      end else if (csum[l] < -lim_cmd) begin
        cclamp[l] = -lim_cmd;
      end else begin
        cclamp[l] = csum[l];
      end
      if (cclamp[l][CW:A-1] == '0 || cclamp[l][CW:A-1] == '1) begin
        csat[l] = cclamp[l][A-1:0];
      end else begin
        csat[l] = {cclamp[l][CW], {(A-1){~cclamp[l][CW]}}};
      end
    end
  end

  // filter state and seed flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q[0] <= '0;
      filt_q[1] <= '0;
      seeded_q  <= 1'b0;
    end else if (state_q == alhr_pkg::ST_FUPD) begin
      seeded_q <= 1'b1;
      for (int l = 0; l < 2; l++) begin
        filt_q[l] <= seeded_q ? fsat[l] : ms_q[l];
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      alhr_pkg::ST_IDLE: begin
        if (accept) begin
          en_q    <= in_enable;
          mbits_q <= alpha_q;
          cnt_q   <= '0;
          for (int l = 0; l < 2; l++) begin
            sp_q[l]  <= in_sp[l];
            ms_q[l]  <= in_ms[l];
            d_q[l]   <= in_diff[l];
            acc_q[l] <= '0;
            lsb_q[l] <= 1'b0;
          end
        end
      end
      alhr_pkg::ST_FILT, alhr_pkg::ST_HOLD: begin
        mbits_q <= mbits_q >> 1;
        cnt_q   <= cnt_q + 1'b1;
        for (int l = 0; l < 2; l++) begin
          acc_q[l] <= step_sum[l][A+2:1];
          lsb_q[l] <= step_sum[l][0];
        end
      end
      alhr_pkg::ST_HLOAD: begin
        mbits_q <= gain_q;
        cnt_q   <= '0;
        for (int l = 0; l < 2; l++) begin
          d_q[l]   <= hold_diff[l];
          acc_q[l] <= '0;
          lsb_q[l] <= 1'b0;
        end
      end
      alhr_pkg::ST_CORR: begin
        for (int l = 0; l < 2; l++) begin
          corr_q[l] <= corr_clamp[l];
        end
      end
      alhr_pkg::ST_CMD: begin
        if (out_load) begin
          hold_q <= en_q;
          for (int l = 0; l < 2; l++) begin
            cmd_q[l] <= en_q ? csat[l] : sp_q[l];
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'({cmd_q[1], cmd_q[0]});
  assign m_axis_tuser_o  = hold_q;

endmodule

// File: tb/tb_attitude_level_hold_regulator.sv
// Self-checking bench for attitude_level_hold_regulator: streams attitude ticks,
// predicts each roll/pitch command in a scoreboard class and compares field by field.
// Depends on alhr_pkg and the regulator RTL only.
module tb_attitude_level_hold_regulator;

  localparam int unsigned AB         = alhr_pkg::ANGLE_BITS_DEF;
  localparam int unsigned UW         = alhr_pkg::IN_USER_W;
  localparam int unsigned IW         = alhr_pkg::CFG_IDX_W;
  localparam int unsigned DW         = alhr_pkg::CFG_DATA_W;
  localparam int unsigned IN_DATA_W  = ((4*AB+19+7)/8)*8;
  localparam int unsigned OUT_DATA_W = ((2*AB+7)/8)*8;
  localparam int unsigned CNT_LSB    = 4*AB;      // contact_count in tdata
  localparam int unsigned MRG_LSB    = 4*AB+3;    // stability_margin in tdata
  localparam longint ANGLE_MAX = (longint'(1) << (AB-1)) - 1;
  localparam longint ANGLE_MIN = -ANGLE_MAX - 1;

  // tuser flag groups
  localparam logic [UW-1:0] SP_OK  =
    UW'((1 << alhr_pkg::U_ROLL_SP_OK) | (1 << alhr_pkg::U_PITCH_SP_OK));
  localparam logic [UW-1:0] MS_OK  =
    UW'((1 << alhr_pkg::U_ROLL_MS_OK) | (1 << alhr_pkg::U_PITCH_MS_OK));
  localparam logic [UW-1:0] OK_ALL = SP_OK | MS_OK;
  localparam logic [UW-1:0] MEAS   = UW'(1 << alhr_pkg::U_POSE_MEAS);
  localparam logic [UW-1:0] INFER  = UW'(1 << alhr_pkg::U_POSE_INFER);

  localparam int NUM_SETTINGS = 7;
  localparam int PHASE_TICKS  = 160;
  localparam int LONG_STALL   = 300;   // receiver hold-off, cycles

  typedef struct {
    logic signed [AB-1:0]  roll_sp;
    logic signed [AB-1:0]  pitch_sp;
    logic signed [AB-1:0]  roll_ms;
    logic signed [AB-1:0]  pitch_ms;
    logic [UW-1:0]         flags;
    logic [2:0]            contacts;
    logic signed [15:0]    margin;
  } tick_t;

  typedef struct {
    logic [AB-1:0] roll_out;
    logic [AB-1:0] pitch_out;
    logic          hold;
  } command_t;

  typedef struct {
    int gain, max_corr, max_cmd, min_contacts, min_margin, alpha;
  } reg_set_t;

  // Scoreboard: mirrors the register file and the low-pass state, predicts
  // one command per accepted tick, checks commands in order.
  class level_hold_scoreboard;
    int gain, max_corr, max_cmd, min_contacts, min_margin, alpha;
    longint roll_flt, pitch_flt;
    bit seeded;
    command_t cmd_q[$];
    int unsigned ticks, commands, holds, errors;

    function new();
      gain         = alhr_pkg::GAIN_RST;
      max_corr     = alhr_pkg::MAX_CORRECTION_RST;
      max_cmd      = alhr_pkg::MAX_COMMAND_RST;
      min_contacts = alhr_pkg::MIN_CONTACTS_RST;
      min_margin   = alhr_pkg::MIN_MARGIN_RST;
      alpha        = alhr_pkg::FILTER_ALPHA_RST;
      roll_flt     = 0;
      pitch_flt    = 0;
      seeded       = 1'b0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
      case (idx)
        alhr_pkg::CFG_GAIN:           gain = val;
        alhr_pkg::CFG_MAX_CORRECTION: max_corr = val[14:0];
        alhr_pkg::CFG_MAX_COMMAND:    max_cmd = val[14:0];
        alhr_pkg::CFG_MIN_CONTACTS:   min_contacts = val[2:0];
        alhr_pkg::CFG_MIN_MARGIN:     min_margin = $signed(val);
        alhr_pkg::CFG_FILTER_ALPHA:   alpha = val;
        default: ;
      endcase
    endfunction

    function longint clip_angle(longint v);
      if (v > ANGLE_MAX) return ANGLE_MAX;
      if (v < ANGLE_MIN) return ANGLE_MIN;
      return v;
    endfunction

    function longint limit_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // >>> on a signed longint floors, as the block's truncation does
    function longint blend(longint est, longint meas);
      return clip_angle(est + ((longint'(alpha) * (meas - est)) >>> 15));
    endfunction

    function longint level_axis(longint sp, longint est);
      longint corr;
      corr = limit_sym((longint'(gain) * (sp - est)) >>> 15, max_corr);
      return clip_angle(limit_sym(sp + corr, max_cmd));
    endfunction

    function void note_tick(tick_t t);
      longint rsp, psp, rms, pms, rc, pc;
      bit enable;
      command_t c;
      rsp = t.flags[alhr_pkg::U_ROLL_SP_OK]  ? longint'(t.roll_sp)  : 0;
      psp = t.flags[alhr_pkg::U_PITCH_SP_OK] ? longint'(t.pitch_sp) : 0;
      rms = t.flags[alhr_pkg::U_ROLL_MS_OK]  ? longint'(t.roll_ms)  : 0;
      pms = t.flags[alhr_pkg::U_PITCH_MS_OK] ? longint'(t.pitch_ms) : 0;
      enable = t.flags[alhr_pkg::U_POSE_MEAS] ||
               (t.flags[alhr_pkg::U_POSE_INFER] && int'(t.contacts) >= min_contacts &&
                int'(t.margin) >= min_margin);
      if (!seeded) begin
        roll_flt  = rms;
        pitch_flt = pms;
        seeded    = 1'b1;
      end else begin
        roll_flt  = blend(roll_flt, rms);
        pitch_flt = blend(pitch_flt, pms);
      end
      rc = enable ? level_axis(rsp, roll_flt)  : rsp;
      pc = enable ? level_axis(psp, pitch_flt) : psp;
      c.roll_out  = rc[AB-1:0];
      c.pitch_out = pc[AB-1:0];
      c.hold      = enable;
      cmd_q.push_back(c);
      ticks++;
    endfunction

    function void compare(string what, logic [AB-1:0] want, logic [AB-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, what, $signed(want), $signed(got));
      end
    endfunction

    function void check_command(command_t got);
      command_t want;
      if (cmd_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected command, expected none, actual roll %0d pitch %0d hold %0b",
                 $time, $signed(got.roll_out), $signed(got.pitch_out), got.hold);
        return;
      end
      want = cmd_q.pop_front();
      commands++;
      if (want.hold) holds++;
      compare("roll_command", want.roll_out, got.roll_out);
      compare("pitch_command", want.pitch_out, got.pitch_out);
      compare("hold_active", AB'(want.hold), AB'(got.hold));
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction

    function void closeout();
      if (cmd_q.size() != 0) begin
        errors++;
        $display("%0t: %0d commands expected but never produced", $time, cmd_q.size());
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [UW-1:0]         s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [IW-1:0]         cfg_index_i = '0;
  logic [DW-1:0]         cfg_data_i = '0;

  level_hold_scoreboard sb = new();

  int send_idle_pct = 0;   // chance per cycle that the sender holds tvalid low
  int recv_idle_pct = 0;   // chance per cycle that the receiver drops tready
  int stall_req  = 0;      // bumped by the stimulus to ask for a long hold-off
  int stall_done = 0;      // owned by the receiver process
  int stall_left = 0;

  reg_set_t plan [NUM_SETTINGS];

  attitude_level_hold_regulator #(.ANGLE_BITS(AB)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random tready, or a long hold-off on request. The hold-off is
  // counted here so the sender keeps offering words and the block backs up
  // into its input.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (stall_req != stall_done) begin
      stall_done++;
      stall_left = LONG_STALL - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: everything sampled at the rising edge, before the block updates.
  // Register writes and accepted ticks go to the predictor, commands to the check.
  always @(posedge clk_i) begin
    tick_t    seen;
    command_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        seen.roll_sp  = s_axis_tdata_i[0 +: AB];
        seen.pitch_sp = s_axis_tdata_i[AB +: AB];
        seen.roll_ms  = s_axis_tdata_i[2*AB +: AB];
        seen.pitch_ms = s_axis_tdata_i[3*AB +: AB];
        seen.contacts = s_axis_tdata_i[CNT_LSB +: 3];
        seen.margin   = s_axis_tdata_i[MRG_LSB +: 16];
        seen.flags    = s_axis_tuser_i;
        sb.note_tick(seen);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.roll_out  = m_axis_tdata_o[0 +: AB];
        got.pitch_out = m_axis_tdata_o[AB +: AB];
        got.hold      = m_axis_tuser_o;
        sb.check_command(got);
      end
    end
  end

  // Offer one tick, with random idle cycles in front; returns at the
  // accepting edge, tvalid still high so back-to-back words stay seamless.
  task automatic send_tick(tick_t t);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[0 +: AB]       = t.roll_sp;
    word[AB +: AB]      = t.pitch_sp;
    word[2*AB +: AB]    = t.roll_ms;
    word[3*AB +: AB]    = t.pitch_ms;
    word[CNT_LSB +: 3]  = t.contacts;
    word[MRG_LSB +: 16] = t.margin;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tuser_i  <= t.flags;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stop offering and wait until every predicted command has been taken.
  // Each tick yields a command, so an empty queue means the sequencer is idle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [IW-1:0] idx, int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[DW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(reg_set_t r);
    cfg_write(alhr_pkg::CFG_GAIN, r.gain);
    cfg_write(alhr_pkg::CFG_MAX_CORRECTION, r.max_corr);
    cfg_write(alhr_pkg::CFG_MAX_COMMAND, r.max_cmd);
    cfg_write(alhr_pkg::CFG_MIN_CONTACTS, r.min_contacts);
    cfg_write(alhr_pkg::CFG_MIN_MARGIN, r.min_margin);
    cfg_write(alhr_pkg::CFG_FILTER_ALPHA, r.alpha);
  endtask

  function automatic tick_t mk_tick(longint rsp, longint psp, longint rms, longint pms,
                                    logic [UW-1:0] flags, int contacts, int margin);
    tick_t t;
    t.roll_sp  = AB'(rsp);
    t.pitch_sp = AB'(psp);
    t.roll_ms  = AB'(rms);
    t.pitch_ms = AB'(pms);
    t.flags    = flags;
    t.contacts = contacts[2:0];
    t.margin   = margin[15:0];
    return t;
  endfunction

  // Angle mix: full range, near level, moderate tilt, and the rails.
  function automatic logic signed [AB-1:0] rand_angle();
    case ($urandom_range(3))
      0: return AB'($urandom);
      1: return AB'(int'($urandom_range(800)) - 400);
      2: return AB'(int'($urandom_range(8000)) - 4000);
      default: begin
        case ($urandom_range(3))
          0: return AB'(ANGLE_MAX);
          1: return AB'(ANGLE_MIN);
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Validity flags mostly set; margin often close to the current threshold
  // so the support comparison flips both ways.
  function automatic tick_t rand_tick();
    tick_t t;
    t.roll_sp  = rand_angle();
    t.pitch_sp = rand_angle();
    t.roll_ms  = rand_angle();
    t.pitch_ms = rand_angle();
    t.flags[alhr_pkg::U_ROLL_SP_OK]  = ($urandom_range(7) != 0);
    t.flags[alhr_pkg::U_PITCH_SP_OK] = ($urandom_range(7) != 0);
    t.flags[alhr_pkg::U_ROLL_MS_OK]  = ($urandom_range(7) != 0);
    t.flags[alhr_pkg::U_PITCH_MS_OK] = ($urandom_range(7) != 0);
    t.flags[alhr_pkg::U_POSE_MEAS]   = 1'($urandom_range(1));
    t.flags[alhr_pkg::U_POSE_INFER]  = 1'($urandom_range(1));
    t.contacts = 3'($urandom_range(7));
    if ($urandom_range(2) == 0) t.margin = 16'($urandom);
    else t.margin = 16'(sb.min_margin + int'($urandom_range(4)) - 2);
    return t;
  endfunction

  initial begin
    tick_t directed [$];

    // register plans: defaults, all-ones, all-zero limits, unity blend,
    // over-unity blend with a tight correction, and two random ones
    plan[0] = '{19661, 1475, 2458, 3, 100, 8192};
    plan[1] = '{65535, 32767, 32767, 7, 32767, 65535};
    plan[2] = '{0, 0, 0, 0, -32768, 0};
    plan[3] = '{32768, 4000, 8000, 6, 0, 32768};
    plan[4] = '{int'($urandom_range(65535)), int'($urandom_range(32767)),
                int'($urandom_range(32767)), int'($urandom_range(7)),
                int'($urandom_range(65535)) - 32768, int'($urandom_range(65535))};
    plan[5] = '{65535, 100, 32767, 1, -50, 40000};
    plan[6] = '{int'($urandom_range(65535)), int'($urandom_range(4000)),
                int'($urandom_range(32767)), int'($urandom_range(7)),
                int'($urandom_range(400)) - 200, int'($urandom_range(65535))};

    // directed ticks under the reset register values; the first one seeds
    // the low-pass estimate
    directed.push_back(mk_tick(0, 0, 1000, -1000, OK_ALL | MEAS, 6, 500));
    directed.push_back(mk_tick(ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, ANGLE_MAX, OK_ALL | MEAS, 6, 500));
    directed.push_back(mk_tick(ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN, OK_ALL | MEAS, 6, 500));
    directed.push_back(mk_tick(2000, -2000, 0, 0, OK_ALL | MEAS, 3, 100));
    // invalid setpoints, invalid measurements, nothing valid
    directed.push_back(mk_tick(12345, -12345, -8000, 8000, MS_OK | MEAS, 6, 500));
    directed.push_back(mk_tick(1500, -1500, 9000, -9000, SP_OK | MEAS, 6, 500));
    directed.push_back(mk_tick(-1, -1, -1, -1, MEAS, 0, 0));
    // no pose source: setpoint passes straight through
    directed.push_back(mk_tick(3000, -3000, 100, 100, OK_ALL, 6, 32767));
    // inferred pose at and just below the support thresholds
    directed.push_back(mk_tick(3000, -3000, 100, 100, OK_ALL | INFER, 3, 100));
    directed.push_back(mk_tick(3000, -3000, 100, 100, OK_ALL | INFER, 2, 100));
    directed.push_back(mk_tick(3000, -3000, 100, 100, OK_ALL | INFER, 3, 99));
    // seven contacts, beyond a real support polygon
    directed.push_back(mk_tick(-2500, 2500, 300, -300, OK_ALL | INFER, 7, 32767));
    // both pose flags with no support: measured alone enables hold
    directed.push_back(mk_tick(-4000, 4000, 500, -500, OK_ALL | MEAS | INFER, 0, -32768));
    directed.push_back(mk_tick(-4000, 4000, 500, -500, OK_ALL | MEAS, 0, -32768));
    directed.push_back(mk_tick(-4000, 4000, 500, -500, OK_ALL | INFER, 6, -32768));
    directed.push_back(mk_tick(ANGLE_MIN, ANGLE_MIN, ANGLE_MAX, ANGLE_MAX,
                               OK_ALL | MEAS | INFER, 7, -1));
    directed.push_back(mk_tick(0, 0, 0, 0, '0, 0, 0));
    directed.push_back(mk_tick(1, -1, ANGLE_MIN, ANGLE_MIN, OK_ALL | MEAS, 4, -100));
    directed.push_back(mk_tick(-20000, 20000, 20000, -20000, OK_ALL | INFER, 5, 1000));

    // reset asserted from time zero and released once
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 46;
    foreach (directed[i]) send_tick(directed[i]);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      // swap idle mix after the first two plans, then run with no idling
      if (s == 2) begin
        send_idle_pct = 46;
        recv_idle_pct = 18;
      end else if (s == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      program_regs(plan[s]);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (s == 1 && n == 40) stall_req++;
        send_tick(rand_tick());
      end
    end

    drain();
    // give any stray command time to show up
    repeat (80) @(negedge clk_i);
    sb.closeout();

    $display("Run covered %0d ticks under the reset values and %0d register plans,",
             sb.ticks, NUM_SETTINGS);
    $display("%0d commands checked, %0d of them with level hold applied.",
             sb.commands, sb.holds);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run ends well before this timeout even with every
  // stall at its worst, so the margin is ample.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
